// ===== sv/slrx_pkg.sv =====
package slrx_pkg;

  localparam int unsigned LEN_W      = 12;
  localparam int unsigned CODE_W     = 16;
  localparam int unsigned RETRY_W    = 5;
  localparam int unsigned MAXRETRY_W = 4;
  localparam int unsigned TICK_W     = 32;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 32;

  localparam logic [7:0] CH_STX = 8'h02;
  localparam logic [7:0] CH_ETX = 8'h03;
  localparam logic [7:0] CH_ACK = 8'h06;
  localparam logic [7:0] CH_NAK = 8'h15;
  localparam logic [7:0] CH_Q   = 8'h51;

  // body offsets that carry the transaction code
  localparam logic [LEN_W-1:0] CODE_HI_OFF = LEN_W'(8);
  localparam logic [LEN_W-1:0] CODE_LO_OFF = LEN_W'(9);

  typedef enum logic [2:0] {
    PH_IDLE = 3'd0,
    PH_HUNT = 3'd1,
    PH_BODY = 3'd2,
    PH_ETX  = 3'd3,
    PH_LRC  = 3'd4,
    PH_DONE = 3'd5
  } phase_e;

  typedef enum logic [1:0] {
    CMD_START = 2'd0,
    CMD_BYTE  = 2'd1,
    CMD_TICK  = 2'd2
  } cmd_e;

  typedef enum logic [2:0] {
    EV_NONE      = 3'd0,
    EV_FRAME_OK  = 3'd1,
    EV_LRC_RETRY = 3'd2,
    EV_GIVE_UP   = 3'd3,
    EV_TIMEOUT   = 3'd4,
    EV_NO_ETX    = 3'd5
  } event_e;

  typedef enum logic [1:0] {
    KIND_NORMAL  = 2'd0,
    KIND_QR      = 2'd1,
    KIND_INVOICE = 2'd2
  } kind_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_NORMAL_SIZE   = 3'd0,
    REG_QR_SIZE       = 3'd1,
    REG_INVOICE_SIZE  = 3'd2,
    REG_INVOICE_CODE  = 3'd3,
    REG_MAX_RETRIES   = 3'd4,
    REG_TIMEOUT_TICKS = 3'd5,
    REG_NO_ACK        = 3'd6
  } cfg_idx_e;

  typedef struct packed {
    logic [LEN_W-1:0]      normal_size;
    logic [LEN_W-1:0]      qr_size;
    logic [LEN_W-1:0]      invoice_size;
    logic [CODE_W-1:0]     invoice_code;
    logic [MAXRETRY_W-1:0] max_retries;
    logic [TICK_W-1:0]     timeout_ticks;
    logic                  no_ack;
  } cfg_t;

  typedef struct packed {
    logic [1:0] command;
    logic [7:0] rx_byte;
  } item_t;

  typedef struct packed {
    logic       data_valid;
    logic [7:0] data_byte;
    event_e     event_res;
    logic       reply_valid;
    logic [7:0] reply_byte;
    kind_e      frame_kind;
  } result_t;

endpackage

// ===== sv/slrx_cfg_regs.sv =====
module slrx_cfg_regs (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             we_i,
  input  logic [slrx_pkg::CFG_IDX_W-1:0]   idx_i,
  input  logic [slrx_pkg::CFG_DATA_W-1:0]  wdata_i,
  output slrx_pkg::cfg_t                   cfg_o
);
  import slrx_pkg::*;

  cfg_t cfg_q, cfg_d;

  always_comb begin
    cfg_d = cfg_q;
    if (we_i) begin
      case (cfg_idx_e'(idx_i))
        REG_NORMAL_SIZE:   cfg_d.normal_size   = wdata_i[LEN_W-1:0];
        REG_QR_SIZE:       cfg_d.qr_size       = wdata_i[LEN_W-1:0];
        REG_INVOICE_SIZE:  cfg_d.invoice_size  = wdata_i[LEN_W-1:0];
        REG_INVOICE_CODE:  cfg_d.invoice_code  = wdata_i[CODE_W-1:0];
        REG_MAX_RETRIES:   cfg_d.max_retries   = wdata_i[MAXRETRY_W-1:0];
        REG_TIMEOUT_TICKS: cfg_d.timeout_ticks = wdata_i[TICK_W-1:0];
        REG_NO_ACK:        cfg_d.no_ack        = wdata_i[0];
        default:           cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.normal_size   <= LEN_W'(400);
      cfg_q.qr_size       <= LEN_W'(1000);
      cfg_q.invoice_size  <= LEN_W'(2044);
      cfg_q.invoice_code  <= CODE_W'(16'h3633); // ASCII "63"
      cfg_q.max_retries   <= MAXRETRY_W'(3);
      cfg_q.timeout_ticks <= TICK_W'(1000);
      cfg_q.no_ack        <= 1'b0;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

// ===== sv/slrx_in_stage.sv =====
module slrx_in_stage (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          s_axis_tvalid_i,
  output logic          s_axis_tready_o,
  input  logic [7:0]    s_axis_tdata_i,  // [7:0] rx_byte
  input  logic [1:0]    s_axis_tuser_i,  // [1:0] command
  input  logic          take_i,
  output logic          valid_o,
  output slrx_pkg::item_t item_o
);
  import slrx_pkg::*;

  logic  in_v_q, in_v_d;
  item_t item_q;
  logic  accept;

  assign s_axis_tready_o = !in_v_q || take_i;
  assign accept          = s_axis_tvalid_i && s_axis_tready_o;

  always_comb begin
    in_v_d = in_v_q;
    if (accept) begin
      in_v_d = 1'b1;
    end else if (take_i) begin
      in_v_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_v_q <= 1'b0;
    end else begin
      in_v_q <= in_v_d;
    end
  end

  // payload, no reset
  always_ff @(posedge clk_i) begin
    if (accept) begin
      item_q.command <= s_axis_tuser_i;
      item_q.rx_byte <= s_axis_tdata_i;
    end
  end

  assign valid_o = in_v_q;
  assign item_o  = item_q;

endmodule

// ===== sv/slrx_proto.sv =====
module slrx_proto (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  slrx_pkg::cfg_t    cfg_i,
  input  logic              step_i,
  input  slrx_pkg::item_t   item_i,
  output slrx_pkg::result_t res_o
);
  import slrx_pkg::*;

  phase_e                 phase_q, phase_d;
  logic [LEN_W-1:0]       byte_cnt_q, byte_cnt_d;
  logic [7:0]             lrc_q, lrc_d;
  logic [LEN_W-1:0]       body_len_q, body_len_d;
  kind_e                  kind_q, kind_d;
  logic                   decided_q, decided_d;
  logic [7:0]             code_hi_q, code_hi_d;
  logic [RETRY_W-1:0]     retry_q, retry_d;
  logic [TICK_W-1:0]      tick_q, tick_d;

  logic                   active;
  logic [7:0]             rx;
  logic [TICK_W-1:0]      tick_inc;
  logic [LEN_W-1:0]       cnt_inc;
  logic [LEN_W-1:0]       len_n;
  logic [RETRY_W-1:0]     retry_inc;
  result_t                res;

  assign rx        = item_i.rx_byte;
  assign active    = (phase_q == PH_HUNT) || (phase_q == PH_BODY) ||
                     (phase_q == PH_ETX)  || (phase_q == PH_LRC);
  assign tick_inc  = (tick_q == '1) ? tick_q : tick_q + TICK_W'(1);
  assign cnt_inc   = byte_cnt_q + LEN_W'(1);
  assign retry_inc = retry_q + RETRY_W'(1);

  always_comb begin
    phase_d    = phase_q;
    byte_cnt_d = byte_cnt_q;
    lrc_d      = lrc_q;
    body_len_d = body_len_q;
    kind_d     = kind_q;
    decided_d  = decided_q;
    code_hi_d  = code_hi_q;
    retry_d    = retry_q;
    tick_d     = tick_q;
    len_n      = body_len_q;

    res             = '0;
    res.event_res   = EV_NONE;

    case (cmd_e'(item_i.command))
      CMD_START: begin
        retry_d    = '0;
        tick_d     = '0;
        byte_cnt_d = '0;
        lrc_d      = '0;
        body_len_d = cfg_i.normal_size;
        kind_d     = KIND_NORMAL;
        decided_d  = 1'b0;
        code_hi_d  = '0;
        phase_d    = PH_HUNT;
      end
      CMD_TICK: begin
        if (active) begin
          tick_d = tick_inc;
          if (tick_inc >= cfg_i.timeout_ticks) begin
            res.event_res = EV_TIMEOUT;
            phase_d       = PH_DONE;
          end
        end
      end
      CMD_BYTE: begin
        if (active) begin
          case (phase_q)
            PH_HUNT: begin
              if (rx == CH_STX) begin
                // each frame restarts length detection
                byte_cnt_d = '0;
                lrc_d      = '0;
                body_len_d = cfg_i.normal_size;
                kind_d     = KIND_NORMAL;
                decided_d  = 1'b0;
                code_hi_d  = '0;
                phase_d    = (cfg_i.normal_size == '0) ? PH_ETX : PH_BODY;
              end
            end
            PH_BODY: begin
              res.data_valid = 1'b1;
              res.data_byte  = rx;
              lrc_d          = lrc_q ^ rx;
              if (byte_cnt_q == '0 && !decided_q && rx == CH_Q) begin
                decided_d = 1'b1;
                kind_d    = KIND_QR;
                len_n     = cfg_i.qr_size;
              end else if (byte_cnt_q == CODE_HI_OFF) begin
                code_hi_d = rx;
              end else if (byte_cnt_q == CODE_LO_OFF && !decided_q &&
                           {code_hi_q, rx} == cfg_i.invoice_code) begin
                decided_d = 1'b1;
                kind_d    = KIND_INVOICE;
                len_n     = cfg_i.invoice_size;
              end
              body_len_d = len_n;
              byte_cnt_d = cnt_inc;
              // a length that shrinks below the count ends the body at once
              if (cnt_inc >= len_n) begin
                phase_d = PH_ETX;
              end
            end
            PH_ETX: begin
              if (rx == CH_ETX) begin
                lrc_d   = lrc_q ^ CH_ETX;
                phase_d = PH_LRC;
              end else begin
                res.event_res = EV_NO_ETX;
                phase_d       = PH_HUNT;
              end
            end
            PH_LRC: begin
              if (rx == lrc_q) begin
                res.event_res = EV_FRAME_OK;
                if (!cfg_i.no_ack) begin
                  res.reply_valid = 1'b1;
                  res.reply_byte  = CH_ACK;
                end
                phase_d = PH_DONE;
              end else begin
                res.reply_valid = 1'b1;
                res.reply_byte  = CH_NAK;
                retry_d         = retry_inc;
                if (retry_inc > {1'b0, cfg_i.max_retries}) begin
                  res.event_res = EV_GIVE_UP;
                  phase_d       = PH_DONE;
                end else begin
                  res.event_res = EV_LRC_RETRY;
                  phase_d       = PH_HUNT;
                end
              end
            end
            default: phase_d = phase_q;
          endcase
        end
      end
      default: phase_d = phase_q;
    endcase

    res.frame_kind = kind_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q    <= PH_IDLE;
      byte_cnt_q <= '0;
      lrc_q      <= '0;
      body_len_q <= LEN_W'(400);
      kind_q     <= KIND_NORMAL;
      decided_q  <= 1'b0;
      code_hi_q  <= '0;
      retry_q    <= '0;
      tick_q     <= '0;
    end else if (step_i) begin
      phase_q    <= phase_d;
      byte_cnt_q <= byte_cnt_d;
      lrc_q      <= lrc_d;
      body_len_q <= body_len_d;
      kind_q     <= kind_d;
      decided_q  <= decided_d;
      code_hi_q  <= code_hi_d;
      retry_q    <= retry_d;
      tick_q     <= tick_d;
    end
  end

  assign res_o = res;

  a_body_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res.data_valid |-> (res.event_res == EV_NONE) && !res.reply_valid)
    else $error("body beat carries an event or reply");

  a_reply_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res.reply_valid |-> (res.reply_byte == CH_ACK) || (res.reply_byte == CH_NAK))
    else $error("reply code is neither ACK nor NAK");

  a_body_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q == PH_BODY) |-> (byte_cnt_q < body_len_q))
    else $error("byte count ran past body length");

  a_ok_ends: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step_i && (res.event_res == EV_FRAME_OK) |=> (phase_q == PH_DONE))
    else $error("good frame did not close the session");

endmodule

// ===== sv/stx_etx_lrc_frame_receiver_core.sv =====
// Pipeline: a beat accepted on the slave side passes the input register, then the frame
//   logic into the result register, which offers its result on the master side.
// Throughput: one beat per cycle; the input register frees as the result register loads,
//   so back pressure from the master side stalls the slave side only when both are full.
// Reset: rst_ni is asynchronous, active low; it empties both registers, puts the session
//   idle until a start command and loads the configuration registers with their defaults.
module stx_etx_lrc_frame_receiver_core (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  // configuration write port
  input  logic                            cfg_we_i,
  input  logic [slrx_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [slrx_pkg::CFG_DATA_W-1:0] cfg_wdata_i,
  // slave side
  input  logic                            s_axis_tvalid_i,
  output logic                            s_axis_tready_o,
  input  logic [7:0]                      s_axis_tdata_i,  // [7:0] rx_byte
  input  logic [1:0]                      s_axis_tuser_i,  // [1:0] command
  // master side
  output logic                            m_axis_tvalid_o,
  input  logic                            m_axis_tready_i,
  output logic [23:0]                     m_axis_tdata_o,  // [7:0] data_byte, [10:8] event_res,
                                                           // [18:11] reply_byte, [23:19] zero
  output logic [3:0]                      m_axis_tuser_o   // [0] data_valid, [1] reply_valid,
                                                           // [3:2] frame_kind
);
  import slrx_pkg::*;

  cfg_t    cfg;
  item_t   item;
  logic    in_valid;
  logic    advance;
  result_t res;
  result_t res_q;
  logic    out_v_q, out_v_d;

  slrx_cfg_regs u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .we_i    (cfg_we_i),
    .idx_i   (cfg_idx_i),
    .wdata_i (cfg_wdata_i),
    .cfg_o   (cfg)
  );

  slrx_in_stage u_in (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .s_axis_tuser_i  (s_axis_tuser_i),
    .take_i          (advance),
    .valid_o         (in_valid),
    .item_o          (item)
  );

  // the frame state moves only when its result has somewhere to go
  assign advance = in_valid && (!out_v_q || m_axis_tready_i);

  slrx_proto u_proto (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg),
    .step_i (advance),
    .item_i (item),
    .res_o  (res)
  );

  always_comb begin
    out_v_d = out_v_q;
    if (advance) begin
      out_v_d = 1'b1;
    end else if (m_axis_tready_i) begin
      out_v_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q <= 1'b0;
    end else begin
      out_v_q <= out_v_d;
    end
  end

  // result payload, no reset
  always_ff @(posedge clk_i) begin
    if (advance) begin
      res_q <= res;
    end
  end

  assign m_axis_tvalid_o = out_v_q;
  assign m_axis_tdata_o  = {5'b0, res_q.reply_byte, res_q.event_res, res_q.data_byte};
  assign m_axis_tuser_o  = {res_q.frame_kind, res_q.reply_valid, res_q.data_valid};

endmodule

// ===== tb/frame_receiver_checker.sv =====
module frame_receiver_checker (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [slrx_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [slrx_pkg::CFG_DATA_W-1:0] cfg_wdata_i,
  input  logic                            s_axis_tvalid_i,
  input  logic                            s_axis_tready_i,
  input  logic [7:0]                      s_axis_tdata_i,
  input  logic [1:0]                      s_axis_tuser_i,
  input  logic                            m_axis_tvalid_i,
  input  logic                            m_axis_tready_i,
  input  logic [23:0]                     m_axis_tdata_i,
  input  logic [3:0]                      m_axis_tuser_i,
  output int unsigned                     pending_o,
  output int unsigned                     fail_count_o
);
  import slrx_pkg::*;

  cfg_t                regs;
  phase_e              sess_phase;
  logic [LEN_W-1:0]    body_cnt;
  logic [LEN_W-1:0]    body_len;
  logic [7:0]          lrc_acc;
  kind_e               kind_q;
  logic                kind_fixed;
  logic [7:0]          code_hi;
  logic [RETRY_W-1:0]  nak_count;
  logic [TICK_W-1:0]   tick_cnt;

  result_t             predicted_beats[$];
  result_t             want;
  result_t             seen;

  initial pending_o = 0;
  initial fail_count_o = 0;

  function automatic void restore_defaults();
    regs.normal_size   = 12'd400;
    regs.qr_size       = 12'd1000;
    regs.invoice_size  = 12'd2044;
    regs.invoice_code  = 16'h3633;
    regs.max_retries   = 4'd3;
    regs.timeout_ticks = 32'd1000;
    regs.no_ack        = 1'b0;
    sess_phase = PH_IDLE;
    body_cnt   = '0;
    lrc_acc    = '0;
    body_len   = regs.normal_size;
    kind_q     = KIND_NORMAL;
    kind_fixed = 1'b0;
    code_hi    = '0;
    nak_count  = '0;
    tick_cnt   = '0;
  endfunction

  // fresh frame after STX: length detection starts over
  function automatic void open_frame();
    body_cnt   = '0;
    lrc_acc    = '0;
    body_len   = regs.normal_size;
    kind_q     = KIND_NORMAL;
    kind_fixed = 1'b0;
    code_hi    = '0;
    sess_phase = (body_len == '0) ? PH_ETX : PH_BODY;
  endfunction

  function automatic void take_body(input logic [7:0] b);
    lrc_acc ^= b;
    if (body_cnt == '0 && !kind_fixed && b == CH_Q) begin
      kind_fixed = 1'b1;
      kind_q     = KIND_QR;
      body_len   = regs.qr_size;
    end else if (body_cnt == CODE_HI_OFF) begin
      code_hi = b;
    end else if (body_cnt == CODE_LO_OFF && !kind_fixed) begin
      if ({code_hi, b} == regs.invoice_code) begin
        kind_fixed = 1'b1;
        kind_q     = KIND_INVOICE;
        body_len   = regs.invoice_size;
      end
    end
    body_cnt = body_cnt + 1'b1;
    // a length that shrank below the bytes taken ends the body at once
    if (body_cnt >= body_len) sess_phase = PH_ETX;
  endfunction

  function automatic result_t predict_beat(input logic [1:0] cmd, input logic [7:0] b);
    result_t r;
    logic    live;
    r    = '0;
    live = (sess_phase >= PH_HUNT) && (sess_phase <= PH_LRC);
    if (cmd == CMD_START) begin
      nak_count = '0;
      tick_cnt  = '0;
      open_frame();
      sess_phase = PH_HUNT;
    end else if (cmd == CMD_TICK && live) begin
      if (tick_cnt != '1) tick_cnt = tick_cnt + 1'b1;
      if (tick_cnt >= regs.timeout_ticks) begin
        r.event_res = EV_TIMEOUT;
        sess_phase  = PH_DONE;
      end
    end else if (cmd == CMD_BYTE && live) begin
      case (sess_phase)
        PH_HUNT: begin
          if (b == CH_STX) open_frame();
        end
        PH_BODY: begin
          r.data_valid = 1'b1;
          r.data_byte  = b;
          take_body(b);
        end
        PH_ETX: begin
          if (b == CH_ETX) begin
            lrc_acc ^= CH_ETX;
            sess_phase = PH_LRC;
          end else begin
            r.event_res = EV_NO_ETX;
            sess_phase  = PH_HUNT;
          end
        end
        default: begin
          if (b == lrc_acc) begin
            r.event_res = EV_FRAME_OK;
            if (!regs.no_ack) begin
              r.reply_valid = 1'b1;
              r.reply_byte  = CH_ACK;
            end
            sess_phase = PH_DONE;
          end else begin
            r.reply_valid = 1'b1;
            r.reply_byte  = CH_NAK;
            nak_count     = nak_count + 1'b1;
            if (nak_count > regs.max_retries) begin
              r.event_res = EV_GIVE_UP;
              sess_phase  = PH_DONE;
            end else begin
              r.event_res = EV_LRC_RETRY;
              sess_phase  = PH_HUNT;
            end
          end
        end
      endcase
    end
    r.frame_kind = kind_q;
    return r;
  endfunction

  function automatic void write_reg(input logic [CFG_IDX_W-1:0] idx,
                                    input logic [CFG_DATA_W-1:0] v);
    case (idx)
      REG_NORMAL_SIZE:   regs.normal_size   = v[LEN_W-1:0];
      REG_QR_SIZE:       regs.qr_size       = v[LEN_W-1:0];
      REG_INVOICE_SIZE:  regs.invoice_size  = v[LEN_W-1:0];
      REG_INVOICE_CODE:  regs.invoice_code  = v[CODE_W-1:0];
      REG_MAX_RETRIES:   regs.max_retries   = v[MAXRETRY_W-1:0];
      REG_TIMEOUT_TICKS: regs.timeout_ticks = v[TICK_W-1:0];
      REG_NO_ACK:        regs.no_ack        = v[0];
      default: ;
    endcase
  endfunction

  function automatic void compare_field(input string fname, input logic [7:0] exp_v,
                                        input logic [7:0] act_v);
    if (act_v !== exp_v) begin
      $error("%s mismatch: expected 'h%0h, got 'h%0h", fname, exp_v, act_v);
      fail_count_o++;
    end
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      restore_defaults();
      predicted_beats.delete();
    end else begin
      if (cfg_we_i) write_reg(cfg_idx_i, cfg_wdata_i);
      if (s_axis_tvalid_i && s_axis_tready_i)
        predicted_beats.push_back(predict_beat(s_axis_tuser_i, s_axis_tdata_i));
      if (m_axis_tvalid_i && m_axis_tready_i) begin
        seen.data_valid  = m_axis_tuser_i[0];
        seen.data_byte   = m_axis_tdata_i[7:0];
        seen.event_res   = event_e'(m_axis_tdata_i[10:8]);
        seen.reply_valid = m_axis_tuser_i[1];
        seen.reply_byte  = m_axis_tdata_i[18:11];
        seen.frame_kind  = kind_e'(m_axis_tuser_i[3:2]);
        if (predicted_beats.size() == 0) begin
          $error("result beat with no prediction pending");
          fail_count_o++;
        end else begin
          want = predicted_beats.pop_front();
          compare_field("data_valid",  8'(want.data_valid),  8'(seen.data_valid));
          compare_field("data_byte",   want.data_byte,       seen.data_byte);
          compare_field("event_res",   8'(want.event_res),   8'(seen.event_res));
          compare_field("reply_valid", 8'(want.reply_valid), 8'(seen.reply_valid));
          compare_field("reply_byte",  want.reply_byte,      seen.reply_byte);
          compare_field("frame_kind",  8'(want.frame_kind),  8'(seen.frame_kind));
        end
      end
    end
    pending_o = predicted_beats.size();
  end

endmodule

// ===== tb/tb.sv =====
module tb;
  import slrx_pkg::*;

  // command code the block must ignore
  localparam logic [1:0] CMD_UNUSED = 2'd3;

  // frame flaws injected by the stimulus
  localparam int FLAW_NONE = 0;
  localparam int FLAW_LRC  = 1;
  localparam int FLAW_ETX  = 2;

  logic                  clk_i = 1'b0;
  logic                  rst_ni = 1'b0;
  logic                  cfg_we_i = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_idx_i = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata_i = '0;
  logic                  s_axis_tvalid_i = 1'b0;
  logic                  s_axis_tready_o;
  logic [7:0]            s_axis_tdata_i = '0;  // [7:0] rx_byte
  logic [1:0]            s_axis_tuser_i = '0;  // [1:0] command
  logic                  m_axis_tvalid_o;
  logic                  m_axis_tready_i = 1'b0;
  logic [23:0]           m_axis_tdata_o;       // [7:0] data_byte, [10:8] event_res,
                                               // [18:11] reply_byte, [23:19] zero
  logic [3:0]            m_axis_tuser_o;       // [0] data_valid, [1] reply_valid,
                                               // [3:2] frame_kind

  int unsigned pending;
  int unsigned fails;

  // idle odds in percent for each side; rx_hold forces a long stall
  int unsigned send_idle_pct = 26;
  int unsigned recv_idle_pct = 79;
  bit          rx_hold = 1'b0;
  int unsigned beats_sent = 0;

  // register settings as last written, so frames can be built to length
  cfg_t cur;

  always #1 clk_i = ~clk_i;

  stx_etx_lrc_frame_receiver_core dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .cfg_idx_i       (cfg_idx_i),
    .cfg_wdata_i     (cfg_wdata_i),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .s_axis_tuser_i  (s_axis_tuser_i),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .m_axis_tuser_o  (m_axis_tuser_o)
  );

  frame_receiver_checker checker_i (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .cfg_idx_i       (cfg_idx_i),
    .cfg_wdata_i     (cfg_wdata_i),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_i (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .s_axis_tuser_i  (s_axis_tuser_i),
    .m_axis_tvalid_i (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_i  (m_axis_tdata_o),
    .m_axis_tuser_i  (m_axis_tuser_o),
    .pending_o       (pending),
    .fail_count_o    (fails)
  );

  // receiver side: random back pressure, or a hard hold-off while rx_hold is set
  always @(negedge clk_i) begin
    m_axis_tready_i <= !rx_hold && ($urandom_range(99) >= recv_idle_pct);
  end

  // watchdog
  initial begin
    #400000;
    $display("Test completed with failures");
    $finish;
  end

  function automatic cfg_t make_cfg(input int unsigned n, input int unsigned q,
                                    input int unsigned inv, input int unsigned code,
                                    input int unsigned retries, input int unsigned ticks,
                                    input bit quiet);
    cfg_t c;
    c.normal_size   = n[LEN_W-1:0];
    c.qr_size       = q[LEN_W-1:0];
    c.invoice_size  = inv[LEN_W-1:0];
    c.invoice_code  = code[CODE_W-1:0];
    c.max_retries   = retries[MAXRETRY_W-1:0];
    c.timeout_ticks = ticks;
    c.no_ack        = quiet;
    return c;
  endfunction

  task automatic write_reg(input cfg_idx_e idx, input logic [CFG_DATA_W-1:0] v);
    @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= v;
    @(posedge clk_i);
  endtask

  // all seven registers, only ever called with the block idle
  task automatic set_config(input cfg_t c);
    cur = c;
    write_reg(REG_NORMAL_SIZE,   CFG_DATA_W'(c.normal_size));
    write_reg(REG_QR_SIZE,       CFG_DATA_W'(c.qr_size));
    write_reg(REG_INVOICE_SIZE,  CFG_DATA_W'(c.invoice_size));
    write_reg(REG_INVOICE_CODE,  CFG_DATA_W'(c.invoice_code));
    write_reg(REG_MAX_RETRIES,   CFG_DATA_W'(c.max_retries));
    write_reg(REG_TIMEOUT_TICKS, CFG_DATA_W'(c.timeout_ticks));
    write_reg(REG_NO_ACK,        CFG_DATA_W'(c.no_ack));
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  // one input beat; random gaps with tvalid low before it, then hold until taken
  task automatic send_beat(input logic [1:0] cmd, input logic [7:0] b);
    @(negedge clk_i);
    while ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid_i <= 1'b0;
      @(negedge clk_i);
    end
    s_axis_tvalid_i <= 1'b1;
    s_axis_tuser_i  <= cmd;
    s_axis_tdata_i  <= b;
    do @(posedge clk_i); while (!s_axis_tready_o);
    beats_sent++;
  endtask

  // serial byte with the odd timer tick slipped in ahead of it
  task automatic send_byte(input logic [7:0] b);
    if ($urandom_range(99) < 8) send_beat(CMD_TICK, 8'($urandom));
    send_beat(CMD_BYTE, b);
  endtask

  // line noise, STX, a body sized the way the block will size it, then ETX and LRC or a non-ETX byte
  task automatic send_frame(input kind_e variant, input int flaw);
    logic [7:0]  b;
    logic [7:0]  acc;
    logic [7:0]  hi;
    int unsigned n;
    int unsigned len;
    repeat ($urandom_range(2)) begin
      b = 8'($urandom);
      if (b == CH_STX) b = 8'h00;
      send_byte(b);
    end
    send_byte(CH_STX);
    len = 32'(cur.normal_size);
    acc = '0;
    hi  = '0;
    n   = 0;
    while (n < len) begin
      b = 8'($urandom);
      if (n == 0) begin
        if (variant == KIND_QR) begin
          b   = CH_Q;
          len = 32'(cur.qr_size);
        end else if (b == CH_Q) begin
          b = ~CH_Q;
        end
      end else if (n == 8) begin
        if (variant == KIND_INVOICE) b = cur.invoice_code[15:8];
        hi = b;
      end else if (n == 9) begin
        if (variant == KIND_INVOICE) begin
          b   = cur.invoice_code[7:0];
          len = 32'(cur.invoice_size);
        end else if (variant == KIND_NORMAL && {hi, b} == cur.invoice_code) begin
          b = ~b;
        end
      end
      send_byte(b);
      acc ^= b;
      n++;
    end
    if (flaw == FLAW_ETX) begin
      b = 8'($urandom);
      if (b == CH_ETX) b = 8'h04;
      send_byte(b);
    end else begin
      send_byte(CH_ETX);
      acc ^= CH_ETX;
      if (flaw == FLAW_LRC) acc ^= 8'($urandom_range(1, 255));
      send_byte(acc);
    end
  endtask

  // start, then up to six frames until one is good or the NAKs run out; sometimes junk after
  task automatic run_session();
    int unsigned naks;
    int unsigned pick;
    int          flaw;
    kind_e       variant;
    naks = 0;
    send_beat(CMD_START, 8'($urandom));
    for (int f = 0; f < 6; f++) begin
      pick    = $urandom_range(99);
      flaw    = (pick < 60) ? FLAW_NONE : (pick < 80) ? FLAW_LRC : FLAW_ETX;
      pick    = $urandom_range(3);
      variant = (pick < 2) ? KIND_NORMAL : (pick == 2) ? KIND_QR : KIND_INVOICE;
      send_frame(variant, flaw);
      if (flaw == FLAW_NONE) break;
      if (flaw == FLAW_LRC) begin
        naks++;
        if (naks > cur.max_retries) break;
      end
    end
    if ($urandom_range(9) == 0) begin
      repeat ($urandom_range(1, 4)) send_beat(2'($urandom), 8'($urandom));
    end
  endtask

  task automatic random_sessions(input int unsigned target);
    int unsigned first;
    first = beats_sent;
    while (beats_sent - first < target) run_session();
  endtask

  // drop tvalid and wait for every predicted beat to come out
  task automatic settle();
    @(negedge clk_i);
    s_axis_tvalid_i <= 1'b0;
    while (pending != 0) @(negedge clk_i);
  endtask

  initial begin
    repeat (10) @(negedge clk_i);
    rst_ni <= 1'b1;

    // directed: tiny lengths, retry limit of one
    set_config(make_cfg(2, 1, 11, 16'h3633, 1, 20, 1'b0));
    send_beat(CMD_BYTE, 8'hFF);     // idle: ignored
    send_beat(CMD_TICK, 8'h00);     // idle: ignored
    send_beat(CMD_UNUSED, 8'h00);   // unknown command
    send_beat(CMD_START, 8'h00);
    send_beat(CMD_BYTE, 8'h00);     // noise while hunting
    send_beat(CMD_BYTE, CH_STX);
    send_beat(CMD_BYTE, CH_Q);      // barcode frame, length shrinks to one
    send_beat(CMD_BYTE, CH_ETX);
    send_beat(CMD_BYTE, 8'h52);     // good LRC, ACK
    send_beat(CMD_BYTE, CH_STX);    // session done: ignored
    send_beat(CMD_TICK, 8'hFF);     // session done: ignored
    send_beat(CMD_START, 8'hFF);
    send_beat(CMD_BYTE, CH_STX);
    send_beat(CMD_BYTE, 8'hFF);
    send_beat(CMD_BYTE, 8'h7F);
    send_beat(CMD_BYTE, 8'hAA);     // ETX missing, back to hunting
    send_beat(CMD_BYTE, CH_STX);
    send_beat(CMD_BYTE, 8'hFF);
    send_beat(CMD_BYTE, 8'h7F);
    send_beat(CMD_BYTE, CH_ETX);
    send_beat(CMD_BYTE, 8'h84);     // bad LRC, NAK and retry
    send_beat(CMD_BYTE, CH_STX);
    send_beat(CMD_BYTE, 8'hFF);
    send_beat(CMD_BYTE, 8'h7F);
    send_beat(CMD_BYTE, CH_ETX);
    send_beat(CMD_BYTE, 8'h00);     // second bad LRC: give up
    settle();

    // directed: empty body, no ACK, zero timeout
    set_config(make_cfg(0, 1, 1, 16'h0000, 0, 0, 1'b1));
    send_beat(CMD_START, 8'h00);
    send_beat(CMD_BYTE, CH_STX);    // ETX expected straight away
    send_beat(CMD_BYTE, CH_ETX);
    send_beat(CMD_BYTE, CH_ETX);    // LRC of an empty body is ETX itself
    send_beat(CMD_START, 8'h00);
    send_beat(CMD_TICK, 8'h00);     // first tick times out
    settle();

    // random sessions, sender mostly busy, receiver mostly stalled
    set_config(make_cfg(12, 5, 20, 16'h3633, 15, 32'hFFFF_FFFF, 1'b0));
    random_sessions(130);
    settle();

    // roles swapped; invoice length shorter than the code offset, short timeout
    send_idle_pct = 79;
    recv_idle_pct = 26;
    set_config(make_cfg(30, 9, 4, 16'h0000, 0, 6, 1'b1));
    random_sessions(120);
    settle();

    // no idling; one frame while the receiver holds off long enough to fill the block
    send_idle_pct = 0;
    recv_idle_pct = 0;
    set_config(make_cfg(16, 16, 16, 16'hFFFF, 15, 32'hFFFF_FFFF, 1'b0));
    fork
      begin
        @(posedge clk_i);
        rx_hold = 1'b1;
        repeat (300) @(posedge clk_i);
        rx_hold = 1'b0;
      end
    join_none
    send_beat(CMD_START, 8'h00);
    send_frame(KIND_NORMAL, FLAW_NONE);
    settle();

    // smallest lengths, a single tick ends the session
    set_config(make_cfg(1, 1, 1, $urandom_range(16'hFFFF), 2, 1, 1'($urandom)));
    random_sessions(100);
    settle();

    repeat (8) @(negedge clk_i);
    if (fails == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
